// ----- rtl/pfde_pkg.sv -----
// ----------------------------------------------------------------------------
// pfde_pkg
// shared types and constants of the page framebuffer draw engine
// ----------------------------------------------------------------------------
package pfde_pkg;

  // command codes carried on the input tuser
  typedef enum logic [2:0] {
    KIND_PIXEL      = 3'd0,
    KIND_RECT       = 3'd1,
    KIND_SCREEN     = 3'd2,
    KIND_INVERT     = 3'd3,
    KIND_BLIT       = 3'd4,
    KIND_READ_BYTE  = 3'd5,
    KIND_READ_PIXEL = 3'd6,
    KIND_NOP        = 3'd7
  } kind_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_e;

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 8;

  // input tdata field offsets, lowest bit first
  localparam int unsigned POS_X_LSB    = 0;
  localparam int unsigned POS_Y_LSB    = 16;
  localparam int unsigned EXTENT_X_LSB = 32;
  localparam int unsigned EXTENT_Y_LSB = 48;
  localparam int unsigned INK_LSB      = 64;
  localparam int unsigned PATTERN_LSB  = 65;
  localparam int unsigned PAT_BITS_LSB = 73;

  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;

endpackage

// ----- rtl/pfde_ram.sv -----
// ----------------------------------------------------------------------------
// pfde_ram
// simple dual-port byte memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfde_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/page_framebuffer_draw_engine_top.sv -----
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_top
// pixel set/clear, blit and fills: a read-modify-write of each byte left after clipping,
// one byte per cycle; an item that covers nothing still passes the sweep state; reads wait
// until the output register can take the result; invert and the unused code leave s_axis_tready high
// after reset a clearing pass zeroes all MAX_COLUMNS * pages bytes (1024 by default)
// with s_axis_tready low; configuration writes are taken throughout
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_top #(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pos_x[15:0] pos_y[31:16] extent_x[47:32] extent_y[63:48] ink[64]
  // pattern[72:65] pattern_bits[76:73] zero[79:77]
  input  logic [pfde_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // kind[2:0]
  input  logic [pfde_pkg::KIND_W-1:0]          s_axis_tuser,
  // read result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // read_data[7:0]
  output logic [pfde_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pfde_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pfde_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // geometry of the store
  localparam int unsigned PAGE_COUNT  = (MAX_ROWS + 7) / 8;
  localparam int unsigned STORE_BYTES = MAX_COLUMNS * PAGE_COUNT;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam int unsigned CW          = $clog2(MAX_COLUMNS);
  localparam int unsigned RW          = $clog2(MAX_ROWS);
  localparam int unsigned PW          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned WW          = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned HW          = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_RESP
  } state_e;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] width_q;
  logic [6:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pfde_pkg::WIDTH_RESET;
      height_q <= pfde_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (pfde_pkg::reg_e'(cfg_index_i))
        pfde_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        pfde_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // area in use, clamped to the store
  logic [WW-1:0] w_used;
  logic [HW-1:0] h_used;

  assign w_used = (9'(width_q) < 9'(MAX_COLUMNS)) ? WW'(width_q) : WW'(MAX_COLUMNS);
  assign h_used = (8'(height_q) < 8'(MAX_ROWS)) ? HW'(height_q) : HW'(MAX_ROWS);

  // --------------------------------------------------------------------------
  // input fields
  // --------------------------------------------------------------------------
  pfde_pkg::kind_e in_kind;
  logic [15:0]     in_pos_x;
  logic [15:0]     in_pos_y;
  logic [15:0]     in_ext_x;
  logic [15:0]     in_ext_y;
  logic            in_ink;
  logic [7:0]      in_pattern;
  logic [3:0]      in_pat_bits;

  assign in_kind     = pfde_pkg::kind_e'(s_axis_tuser);
  assign in_pos_x    = s_axis_tdata[pfde_pkg::POS_X_LSB +: 16];
  assign in_pos_y    = s_axis_tdata[pfde_pkg::POS_Y_LSB +: 16];
  assign in_ext_x    = s_axis_tdata[pfde_pkg::EXTENT_X_LSB +: 16];
  assign in_ext_y    = s_axis_tdata[pfde_pkg::EXTENT_Y_LSB +: 16];
  assign in_ink      = s_axis_tdata[pfde_pkg::INK_LSB];
  assign in_pattern  = s_axis_tdata[pfde_pkg::PATTERN_LSB +: 8];
  assign in_pat_bits = s_axis_tdata[pfde_pkg::PAT_BITS_LSB +: 4];

  // --------------------------------------------------------------------------
  // clipping: every drawing command becomes a rectangle of bytes
  // pixel and reads are 1x1, blit is n x 1, screen fill is the whole area
  // --------------------------------------------------------------------------
  logic signed [17:0] gx, gy, gex, gey;
  logic signed [17:0] w_s, h_s;
  logic signed [17:0] x_end, y_end;
  logic signed [17:0] x0, y0, x1, y1, x1m, y1m, neg_x;
  logic [3:0]         blit_n;
  logic [7:0]         pat_keep;
  logic [7:0]         pat_init;
  logic               geo_empty;
  logic [CW-1:0]      g_xs, g_xl;
  logic [RW-1:0]      g_ys, g_yl;
  logic [PW-1:0]      g_p0, g_pl;
  logic [PW+WW-1:0]   g_prod;
  logic [AW-1:0]      g_base;
  logic [AW-1:0]      g_addr;

  assign w_s    = 18'(w_used);
  assign h_s    = 18'(h_used);
  assign blit_n = (in_pat_bits > 4'd8) ? 4'd8 : in_pat_bits;

  always_comb begin
    gx  = {{2{in_pos_x[15]}}, in_pos_x};
    gy  = {{2{in_pos_y[15]}}, in_pos_y};
    gex = 18'sd1;
    gey = 18'sd1;
    case (in_kind)
      pfde_pkg::KIND_RECT: begin
        gex = {{2{in_ext_x[15]}}, in_ext_x};
        gey = {{2{in_ext_y[15]}}, in_ext_y};
      end
      pfde_pkg::KIND_SCREEN: begin
        gx  = 18'sd0;
        gy  = 18'sd0;
        gex = w_s;
        gey = h_s;
      end
      pfde_pkg::KIND_BLIT: begin
        gex = 18'(blit_n);
      end
      default: ;
    endcase
  end

  assign x_end = gx + gex;
  assign y_end = gy + gey;
  assign x0    = (gx < 18'sd0) ? 18'sd0 : gx;
  assign y0    = (gy < 18'sd0) ? 18'sd0 : gy;
  assign x1    = (x_end < w_s) ? x_end : w_s;
  assign y1    = (y_end < h_s) ? y_end : h_s;
  assign x1m   = x1 - 18'sd1;
  assign y1m   = y1 - 18'sd1;

  assign geo_empty = (gex <= 18'sd0) || (gey <= 18'sd0) || (x0 >= x1) || (y0 >= y1);

  assign g_xs = x0[CW-1:0];
  assign g_xl = x1m[CW-1:0];
  assign g_ys = y0[RW-1:0];
  assign g_yl = y1m[RW-1:0];
  assign g_p0 = PW'(g_ys >> 3);
  assign g_pl = PW'(g_yl >> 3);

  // first byte address, read straight away in the accepting cycle
  assign g_prod = g_p0 * w_used;
  assign g_base = AW'(g_prod);
  assign g_addr = g_base + AW'(g_xs);

  // blit: keep the leading bits in use, drop columns clipped on the left
  assign neg_x    = -gx;
  assign pat_keep = in_pattern & ~(8'hFF >> blit_n);

  always_comb begin
    pat_init = 8'hFF;
    if (in_kind == pfde_pkg::KIND_BLIT) begin
      if (gx >= 18'sd0) begin
        pat_init = pat_keep;
      end else if (neg_x >= 18'sd8) begin
        pat_init = 8'h00;
      end else begin
        pat_init = pat_keep << neg_x[2:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  state_e        state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q, out_data_d;
  logic          inv_q, inv_d;
  logic [AW-1:0] clr_q, clr_d;

  logic          s_acc;
  logic          cursor_load;
  logic          cursor_step;

  // cursor over the bytes of the current command
  logic [CW-1:0] col_q, xs_q, xl_q;
  logic [PW-1:0] page_q, p0_q, pl_q;
  logic [AW-1:0] base_q;
  logic [2:0]    y0lo_q, yllo_q;
  logic          empty_q;
  logic          ink_q;
  logic          blit_q;
  logic          pixel_q;
  logic [7:0]    pat_q;

  logic          col_end, last_byte;
  logic [CW-1:0] nxt_col;
  logic [PW-1:0] nxt_page;
  logic [AW-1:0] nxt_base;
  logic [AW-1:0] cur_addr, nxt_addr;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // byte modification
  logic [2:0]    mask_lo, mask_hi;
  logic [7:0]    mask;
  logic [7:0]    new_byte;
  logic [7:0]    true_byte;
  logic [7:0]    rd_result;
  logic          out_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign cur_addr  = base_q + AW'(col_q);
  assign col_end   = (col_q == xl_q);
  assign last_byte = empty_q || (col_end && (page_q == pl_q));
  assign nxt_col   = col_end ? xs_q : col_q + CW'(1);
  assign nxt_page  = col_end ? page_q + PW'(1) : page_q;
  assign nxt_base  = col_end ? base_q + AW'(w_used) : base_q;
  assign nxt_addr  = nxt_base + AW'(nxt_col);

  // rows of this page inside the fill, gated by the blit column bit
  assign mask_lo = (page_q == p0_q) ? y0lo_q : 3'd0;
  assign mask_hi = (page_q == pl_q) ? yllo_q : 3'd7;
  assign mask    = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi)) & {8{pat_q[7]}};

  // the store holds bytes xor the invert flag, so ink is flipped with it
  assign new_byte  = (ink_q ^ inv_q) ? (ram_rdata | mask) : (ram_rdata & ~mask);
  assign true_byte = ram_rdata ^ {8{inv_q}};

  always_comb begin
    rd_result = 8'h00;
    if (!empty_q) begin
      rd_result = pixel_q ? {7'd0, true_byte[y0lo_q]} : true_byte;
    end
  end

  // read port: first byte while idle, the next byte while sweeping,
  // the held byte while a result waits for the output register
  always_comb begin
    ram_re    = (state_q != ST_CLEAR);
    ram_raddr = g_addr;
    case (state_q)
      ST_SWEEP: ram_raddr = nxt_addr;
      ST_RESP:  ram_raddr = cur_addr;
      default:  ram_raddr = g_addr;
    endcase
  end

  // write port: clearing pass or read-modify-write of the byte read last cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = new_byte;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'h00;
      end
      ST_SWEEP: ram_we = !empty_q;
      default:  ;
    endcase
  end

  assign out_load = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    inv_d       = inv_q;
    clr_d       = clr_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    cursor_load = 1'b0;
    cursor_step = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          cursor_load = 1'b1;
          case (in_kind)
            pfde_pkg::KIND_PIXEL,
            pfde_pkg::KIND_RECT,
            pfde_pkg::KIND_SCREEN,
            pfde_pkg::KIND_BLIT:       state_d = ST_SWEEP;
            pfde_pkg::KIND_READ_BYTE,
            pfde_pkg::KIND_READ_PIXEL: state_d = ST_RESP;
            pfde_pkg::KIND_INVERT:     inv_d   = !inv_q;
            default:                   ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (last_byte) begin
          state_d = ST_IDLE;
        end else begin
          cursor_step = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_result;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      inv_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= 8'h00;
    end else begin
      state_q     <= state_d;
      inv_q       <= inv_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // cursor and command payload
  always_ff @(posedge clk_i) begin
    if (cursor_load) begin
      col_q   <= g_xs;
      page_q  <= g_p0;
      base_q  <= g_base;
      xs_q    <= g_xs;
      xl_q    <= g_xl;
      p0_q    <= g_p0;
      pl_q    <= g_pl;
      y0lo_q  <= g_ys[2:0];
      yllo_q  <= g_yl[2:0];
      empty_q <= geo_empty;
      ink_q   <= in_ink;
      blit_q  <= (in_kind == pfde_pkg::KIND_BLIT);
      pixel_q <= (in_kind == pfde_pkg::KIND_READ_PIXEL);
      pat_q   <= pat_init;
    end else if (cursor_step) begin
      col_q  <= nxt_col;
      page_q <= nxt_page;
      base_q <= nxt_base;
      if (blit_q) begin
        pat_q <= pat_q << 1;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // frame store
  // --------------------------------------------------------------------------
  pfde_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

endmodule

// ----- rtl/pfde_checker.sv -----
// ----------------------------------------------------------------------------
// pfde_checker
// port-level checks of the draw engine, bound to the top level
// ----------------------------------------------------------------------------
module pfde_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [pfde_pkg::KIND_W-1:0]      s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pfde_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // drawing and read items occupy the memory once accepted, so the input is then not ready
  a_busy_after_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == pfde_pkg::KIND_PIXEL || s_axis_tuser == pfde_pkg::KIND_RECT ||
              s_axis_tuser == pfde_pkg::KIND_SCREEN || s_axis_tuser == pfde_pkg::KIND_BLIT ||
              s_axis_tuser == pfde_pkg::KIND_READ_BYTE ||
              s_axis_tuser == pfde_pkg::KIND_READ_PIXEL)
    |=> !s_axis_tready)
    else $error("item accepted during a memory access");

  // invert only flips a flag and a no-op does nothing, so the input is ready again in the cycle after
  a_invert_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == pfde_pkg::KIND_INVERT || s_axis_tuser == pfde_pkg::KIND_NOP)
    |=> s_axis_tready)
    else $error("invert or no-op item held the input");

endmodule

bind page_framebuffer_draw_engine_top pfde_checker u_pfde_checker (.*);
